FILE: rtl/upd_pkg.sv
`default_nettype none

package upd_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ESC  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SLASH = 2'd3;

    localparam logic [BYTE_W-1:0] CH_QUERY   = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

    // One decoded result as it leaves the decode logic.
    typedef struct packed {
        logic                emit;
        logic [BYTE_W-1:0]   data;
        logic                done;
        logic [STATUS_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input logic [BYTE_W-1:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.ok    = 1'b0;
            h.value = 4'd0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/upd_step.sv
`default_nettype none

module upd_step
    import upd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_last,
    output t_result                o_res
);

    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_HIGH  = 2'd1,
        MODE_LOW   = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    t_mode               r_mode, n_mode;
    logic [3:0]          r_high, n_high;
    logic [STATUS_W-1:0] r_err, n_err;
    logic                r_seen, n_seen;
    logic                r_slash, n_slash;

    t_hex                hex;
    logic [BYTE_W-1:0]   esc_val;
    logic                emit;
    logic [BYTE_W-1:0]   ob;
    logic [STATUS_W-1:0] fin_err;
    logic [STATUS_W-1:0] status;

    always_comb begin
        hex     = hex_digit(i_byte);
        esc_val = {r_high, hex.value};
        n_mode  = r_mode;
        n_high  = r_high;
        n_err   = r_err;
        n_seen  = r_seen;
        n_slash = r_slash;
        emit    = 1'b0;
        ob      = CH_NUL;
        fin_err = ST_OK;
        status  = ST_OK;

        if (r_err == ST_OK) begin
            unique case (r_mode)
                MODE_COPY: begin
                    if (i_byte == CH_QUERY) begin
                        n_mode = MODE_QUERY;
                    end else if (i_byte == CH_PERCENT) begin
                        n_mode = MODE_HIGH;
                    end else begin
                        emit = 1'b1;
                        ob   = i_byte;
                    end
                end
                MODE_HIGH: begin
                    if (!hex.ok) begin
                        n_err = ST_BAD_ESC;
                    end else begin
                        n_high = hex.value;
                        n_mode = MODE_LOW;
                    end
                end
                MODE_LOW: begin
                    if (!hex.ok) begin
                        n_err = ST_BAD_ESC;
                    end else if (esc_val == CH_NUL) begin
                        n_err = ST_ZERO;
                    end else begin
                        emit   = 1'b1;
                        ob     = esc_val;
                        n_mode = MODE_COPY;
                    end
                end
                MODE_QUERY: begin
                end
                default: begin
                end
            endcase
        end

        if (emit && !r_seen) begin
            n_seen  = 1'b1;
            n_slash = (ob == CH_SLASH);
        end

        if (i_last) begin
            // An escape still open at the end of the target is truncated.
            fin_err = n_err;
            if (fin_err == ST_OK && (n_mode == MODE_HIGH || n_mode == MODE_LOW)) begin
                fin_err = ST_BAD_ESC;
            end
            if (fin_err != ST_OK) begin
                status = fin_err;
            end else if (!n_seen || !n_slash) begin
                status = ST_NO_SLASH;
            end else begin
                status = ST_OK;
            end
            n_mode  = MODE_COPY;
            n_high  = 4'd0;
            n_err   = ST_OK;
            n_seen  = 1'b0;
            n_slash = 1'b0;
        end

        o_res.emit   = emit;
        o_res.data   = ob;
        o_res.done   = i_last;
        o_res.status = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_COPY;
            r_high  <= 4'd0;
            r_err   <= ST_OK;
            r_seen  <= 1'b0;
            r_slash <= 1'b0;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_high  <= n_high;
            r_err   <= n_err;
            r_seen  <= n_seen;
            r_slash <= n_slash;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/url_path_percent_decoder.sv
`default_nettype none

// URL path percent decoder. Takes one byte of a request target per request
// on the slave side (tlast on the final byte) and gives exactly one result
// per byte on the master side: tuser is high when tdata[7:0] holds a decoded
// path byte, tlast marks the result of the final byte, and on that result
// tdata[9:8] carries the status (0 ok, 1 bad or truncated escape, 2 escape
// decoding to zero, 3 empty path or no leading slash). Bytes from the first
// '?' on are dropped, and after an error nothing more is emitted until the
// end of the target. One byte is taken every cycle while the output side is not
// stalled; a byte passes an input register and the decode logic into the output
// register, which presents its result.
module url_path_percent_decoder
    import upd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [BYTE_W-1:0]     i_s_tdata,   // [7:0] in_byte
    input  wire logic                  i_s_tlast,   // in_last
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,   // [7:0] out_byte, [9:8] out_status
    output logic                       o_m_tuser,   // out_valid
    output logic                       o_m_tlast    // out_done
);

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_vld;
    t_result           r_out;
    t_result           step_res;
    logic              adv;

    assign adv        = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    upd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out.emit;
    assign o_m_tlast  = r_out.done;
    assign o_m_tdata  = {{(OUT_DATA_W-BYTE_W-STATUS_W){1'b0}}, r_out.status, r_out.data};

`ifndef NO_ASSERTIONS
    // A held input byte stays until the decode logic takes it.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld)
        else $error("input register dropped a byte");

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.done |-> r_out.status == ST_OK)
        else $error("status reported before the last byte");

    a_no_byte_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.emit |-> r_out.data == CH_NUL)
        else $error("data present without a decoded byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_m_tready |-> !adv)
        else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_url_path_percent_decoder.sv
`timescale 1ns / 100ps

module tb_url_path_percent_decoder;
    import upd_pkg::*;

    localparam int TARGET_REQUESTS = 1450;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_AT         = 500;
    localparam int HOLD_CYCLES     = 400;

    typedef enum logic [1:0] {
        SCAN_COPY,
        SCAN_HIGH,
        SCAN_LOW,
        SCAN_QUERY
    } t_scan;

    // Tracks the decoder state and keeps the results each accepted byte should produce.
    class decoded_path_board;
        t_scan       scan;
        logic [3:0]  high_nib;
        logic [1:0]  err;
        bit          seen_out;
        bit          first_slash;
        t_result     expected_results[$];
        int          mismatches;
        int          requests_noted;

        function new();
            mismatches     = 0;
            requests_noted = 0;
            clear_target();
        endfunction

        function void clear_target();
            scan        = SCAN_COPY;
            high_nib    = 4'd0;
            err         = ST_OK;
            seen_out    = 1'b0;
            first_slash = 1'b0;
        endfunction

        function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
            v = 4'd0;
            if (c >= "0" && c <= "9") begin
                v = 4'(c - "0");
                return 1'b1;
            end
            if (c >= "a" && c <= "f") begin
                v = 4'(c - "a" + 8'd10);
                return 1'b1;
            end
            if (c >= "A" && c <= "F") begin
                v = 4'(c - "A" + 8'd10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(input logic [7:0] b, input logic last);
            t_result    r;
            logic [3:0] v;
            logic [7:0] dec;
            r = '0;
            if (err == ST_OK) begin
                case (scan)
                    SCAN_COPY: begin
                        if (b == CH_QUERY) begin
                            scan = SCAN_QUERY;
                        end else if (b == CH_PERCENT) begin
                            scan = SCAN_HIGH;
                        end else begin
                            r.emit = 1'b1;
                            r.data = b;
                        end
                    end
                    SCAN_HIGH: begin
                        if (!hex_nibble(b, v)) begin
                            err = ST_BAD_ESC;
                        end else begin
                            high_nib = v;
                            scan     = SCAN_LOW;
                        end
                    end
                    SCAN_LOW: begin
                        if (!hex_nibble(b, v)) begin
                            err = ST_BAD_ESC;
                        end else begin
                            dec = {high_nib, v};
                            if (dec == CH_NUL) begin
                                err = ST_ZERO;
                            end else begin
                                r.emit = 1'b1;
                                r.data = dec;
                                scan   = SCAN_COPY;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (r.emit && !seen_out) begin
                seen_out    = 1'b1;
                first_slash = (r.data == CH_SLASH);
            end
            if (last) begin
                r.done = 1'b1;
                // An escape still open at the end counts as a bad escape.
                if (err == ST_OK && (scan == SCAN_HIGH || scan == SCAN_LOW))
                    err = ST_BAD_ESC;
                if (err != ST_OK)
                    r.status = err;
                else if (!seen_out || !first_slash)
                    r.status = ST_NO_SLASH;
                else
                    r.status = ST_OK;
                clear_target();
            end
            expected_results.insert(expected_results.size(), r);
            requests_noted++;
        endfunction

        function void check_result(input logic [OUT_DATA_W-1:0] data, input logic valid_byte,
                                   input logic done);
            t_result exp;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: tdata=%h tuser=%b tlast=%b",
                             data, valid_byte, done);
                return;
            end
            exp = expected_results.pop_front();
            if (exp.emit !== valid_byte || exp.data !== data[7:0] || exp.done !== done ||
                exp.status !== data[9:8]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected valid=%b byte=%h done=%b status=%0d,",
                              " got valid=%b byte=%h done=%b status=%0d"},
                             exp.emit, exp.data, exp.done, exp.status,
                             valid_byte, data[7:0], done, data[9:8]);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic [BYTE_W-1:0]     i_s_tdata  = '0;
    logic                  i_s_tlast  = 1'b0;
    logic                  i_m_tready = 1'b0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    decoded_path_board board = new();
    logic [7:0]        target_q[$];
    int                cycle_count = 0;
    int                stall_left  = 0;
    bit                hold_done   = 1'b0;

    url_path_percent_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] in_byte
        .i_s_tlast  (i_s_tlast),   // in_last
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [7:0] out_byte, [9:8] out_status
        .o_m_tuser  (o_m_tuser),   // out_valid
        .o_m_tlast  (o_m_tlast)    // out_done
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Both sides stop idling for a stretch in the middle of the run.
    function automatic bit in_calm_stretch();
        return board.requests_noted >= 800 && board.requests_noted < 1100;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'h30 + {4'd0, n};
        return (upper ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        target_q.insert(target_q.size(), b);
    endfunction

    // Receiver: checks results, stalls at random, and once holds off long enough
    // for the decoder to fill up and stall its input.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_done && board.requests_noted >= HOLD_AT) begin
            hold_done  <= 1'b1;
            stall_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= in_calm_stretch() || ($urandom_range(0, 99) >= 27);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!in_calm_stretch() && $urandom_range(0, 99) < 27) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_request(b, last);
    endtask

    task automatic send_target();
        for (int i = 0; i < target_q.size(); i++)
            send_byte(target_q[i], i == target_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        target_q.delete();
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
        send_target();
    endtask

    // Mostly well-formed paths with random bytes and escapes; the rest is noise
    // built from percent signs, hex digits, question marks, slashes and arbitrary bytes.
    task automatic build_random_target();
        int         len;
        int         r;
        logic [7:0] v;
        target_q.delete();
        if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 9) == 0) begin
                append_byte(CH_PERCENT);
                append_byte("2");
                append_byte($urandom_range(0, 1) ? "F" : "f");
            end else begin
                append_byte(CH_SLASH);
            end
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 9);
                if (r < 6) begin
                    do v = 8'($urandom_range(0, 255));
                    while (v == CH_PERCENT || v == CH_QUERY);
                    append_byte(v);
                end else if (r < 9) begin
                    v = 8'($urandom_range(1, 255));
                    append_byte(CH_PERCENT);
                    append_byte(hex_char(v[7:4], 1'($urandom_range(0, 1))));
                    append_byte(hex_char(v[3:0], 1'($urandom_range(0, 1))));
                end else begin
                    append_byte(CH_QUERY);
                    repeat ($urandom_range(0, 4))
                        append_byte(8'($urandom_range(0, 255)));
                    break;
                end
            end
        end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 4))
                    0: append_byte(8'($urandom_range(0, 255)));
                    1: append_byte(CH_PERCENT);
                    2: append_byte(CH_QUERY);
                    3: append_byte(CH_SLASH);
                    default: append_byte(hex_char(4'($urandom_range(0, 15)),
                                                  1'($urandom_range(0, 1))));
                endcase
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("/");
        send_text("%2F%ff");     // decoded leading slash, highest decoded byte
        send_text("/%A");        // ends after the high digit
        send_text("%");          // ends right after the percent sign
        send_text("/%00");       // escape decoding to zero
        send_text("/%?");        // question mark where a hex digit belongs
        send_text("?");          // query only, so the path is empty
        target_q = '{8'h78, CH_NUL};
        send_target();           // raw zero byte, no leading slash
        target_q = '{CH_SLASH, 8'hFF, CH_QUERY, CH_PERCENT};
        send_target();           // raw 0xFF, then the query is dropped

        while (board.requests_noted < TARGET_REQUESTS) begin
            build_random_target();
            send_target();
        end
        i_s_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/upd_pkg.sv
rtl/upd_step.sv
rtl/url_path_percent_decoder.sv
tb/tb_url_path_percent_decoder.sv
